// ===== sv/tpss_pkg.sv =====
`timescale 1ns / 1ps

package tpss_pkg;

   localparam int BLK      = 8;
   localparam int BLK_BITS = 3;

   localparam int DEF_RES_X       = 64;
   localparam int DEF_RES_Y       = 48;
   localparam int DEF_GLYPH_COUNT = 256;

   localparam int NUM_TAPS   = 5;
   localparam int TAP_CENTER = 0;
   localparam int TAP_LEFT   = 1;
   localparam int TAP_RIGHT  = 2;
   localparam int TAP_UP     = 3;
   localparam int TAP_DOWN   = 4;

   localparam int CMD_W      = 2;
   localparam int POS_W      = 6;
   localparam int IDX_W      = 6;
   localparam int TILE_W     = 8;
   localparam int COL_W      = 3;
   localparam int WORD_W     = 16;
   localparam int LEVEL_W    = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_MAP_WR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GLYPH_WR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd2;

   // packed with the first field in the highest bits
   typedef struct packed {
      logic [2:0]        fill;
      logic [WORD_W-1:0] glyph_word;
      logic [COL_W-1:0]  glyph_column;
      logic [TILE_W-1:0] glyph_id;
      logic [TILE_W-1:0] map_tile;
      logic [IDX_W-1:0]  map_index;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_x;
   } req_data_type;

   typedef struct packed {
      logic [BLK_BITS-1:0] col;
      logic [BLK_BITS-1:0] row;
      logic                slot_ok;
   } tap_pos_type;

   typedef struct packed {
      logic h_on;
      logic v_on;
      logic edge_hit;
   } smooth_ctrl_type;

   function automatic int map_depth(input int rx, input int ry);
      return ((rx + BLK - 1) / BLK) * ((ry + BLK - 1) / BLK);
   endfunction

endpackage

// ===== sv/tpss_tap_addr.sv =====
`timescale 1ns / 1ps

module tpss_tap_addr #(
   parameter int RES_X  = tpss_pkg::DEF_RES_X,
   parameter int RES_Y  = tpss_pkg::DEF_RES_Y,
   parameter int SLOT_W = 6
) (
   input  logic [tpss_pkg::POS_W-1:0]    pos_x,
   input  logic [tpss_pkg::POS_W-1:0]    pos_y,
   output logic [SLOT_W-1:0]             slot [tpss_pkg::NUM_TAPS],
   output tpss_pkg::tap_pos_type         tap_pos [tpss_pkg::NUM_TAPS],
   output tpss_pkg::smooth_ctrl_type     ctrl
);
   import tpss_pkg::*;

   localparam int MAP_COLS  = RES_X / BLK;
   localparam int MAP_DEPTH = map_depth(RES_X, RES_Y);
   localparam int XW        = $clog2(RES_X);
   localparam int YW        = $clog2(RES_Y);

   logic [NUM_TAPS-1:0] clamp_hit;
   logic                h_on;
   logic                v_on;

   assign h_on = (pos_x[BLK_BITS-1:0] == '0) || (pos_x[BLK_BITS-1:0] == '1);
   assign v_on = (pos_y[BLK_BITS-1:0] == '0) || (pos_y[BLK_BITS-1:0] == '1);

   always_comb begin
      logic [POS_W:0]  xn;
      logic [POS_W:0]  yn;
      logic            lo_x;
      logic            lo_y;
      logic            hi_x;
      logic            hi_y;
      logic [XW-1:0]   cx;
      logic [YW-1:0]   cy;
      logic [31:0]     slot32;
      for (int i = 0; i < NUM_TAPS; i++) begin
         xn = {1'b0, pos_x};
         yn = {1'b0, pos_y};
         lo_x = 1'b0;
         lo_y = 1'b0;
         if (i == TAP_LEFT) begin
            lo_x = (pos_x == '0);
            xn   = xn - 1'b1;
         end
         if (i == TAP_RIGHT) begin
            xn = xn + 1'b1;
         end
         if (i == TAP_UP) begin
            lo_y = (pos_y == '0);
            yn   = yn - 1'b1;
         end
         if (i == TAP_DOWN) begin
            yn = yn + 1'b1;
         end
         hi_x = !lo_x && (32'(xn) >= RES_X);
         hi_y = !lo_y && (32'(yn) >= RES_Y);
         if (lo_x) begin
            cx = '0;
         end else if (hi_x) begin
            cx = XW'(RES_X - 1);
         end else begin
            cx = XW'(xn);
         end
         if (lo_y) begin
            cy = '0;
         end else if (hi_y) begin
            cy = YW'(RES_Y - 1);
         end else begin
            cy = YW'(yn);
         end
         slot32 = 32'(cx >> BLK_BITS) + 32'(cy >> BLK_BITS) * MAP_COLS;
         slot[i]            = SLOT_W'(slot32);
         tap_pos[i].col     = cx[BLK_BITS-1:0];
         tap_pos[i].row     = cy[BLK_BITS-1:0];
         tap_pos[i].slot_ok = (slot32 < MAP_DEPTH);
         clamp_hit[i]       = lo_x || hi_x || lo_y || hi_y;
      end
   end

   assign ctrl.h_on     = h_on;
   assign ctrl.v_on     = v_on;
   assign ctrl.edge_hit = clamp_hit[TAP_CENTER]
                        || (h_on && (clamp_hit[TAP_LEFT] || clamp_hit[TAP_RIGHT]))
                        || (v_on && (clamp_hit[TAP_UP] || clamp_hit[TAP_DOWN]));

endmodule

// ===== sv/tpss_tap_lane.sv =====
`timescale 1ns / 1ps

module tpss_tap_lane #(
   parameter int GLYPH_COUNT = tpss_pkg::DEF_GLYPH_COUNT,
   parameter int MAP_DEPTH   = 48,
   parameter int SLOT_W      = 6,
   parameter int GLYPH_AW    = 11
) (
   input  logic                            clock,
   input  logic                            adv,
   input  logic                            map_we,
   input  logic [SLOT_W-1:0]               map_waddr,
   input  logic [tpss_pkg::TILE_W-1:0]     map_wdata,
   input  logic                            glyph_we,
   input  logic [GLYPH_AW-1:0]             glyph_waddr,
   input  logic [tpss_pkg::WORD_W-1:0]     glyph_wdata,
   input  logic [SLOT_W-1:0]               rd_slot,
   input  tpss_pkg::tap_pos_type           rd_pos,
   output logic [tpss_pkg::LEVEL_W-1:0]    level
);
   import tpss_pkg::*;

   logic [TILE_W-1:0]  map_mem [MAP_DEPTH];
   logic [WORD_W-1:0]  glyph_mem [GLYPH_COUNT * BLK];

   logic [TILE_W-1:0]  map_rd_ff;
   tap_pos_type        pos1_ff;
   logic [WORD_W-1:0]  glyph_rd_ff;
   logic [BLK_BITS-1:0] row2_ff;
   logic               zero2_ff;

   logic               tile_ok;
   logic [GLYPH_AW-1:0] glyph_raddr;

   assign tile_ok     = (32'(map_rd_ff) < GLYPH_COUNT);
   assign glyph_raddr = GLYPH_AW'(32'(map_rd_ff) * BLK + 32'(pos1_ff.col));

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (adv) begin
         map_rd_ff <= map_mem[rd_slot];
         pos1_ff   <= rd_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[glyph_waddr] <= glyph_wdata;
      end
      if (adv) begin
         glyph_rd_ff <= glyph_mem[glyph_raddr];
         row2_ff     <= pos1_ff.row;
         zero2_ff    <= !(pos1_ff.slot_ok && tile_ok);
      end
   end

   assign level = zero2_ff ? '0
                : {glyph_rd_ff[{1'b1, row2_ff}], glyph_rd_ff[{1'b0, row2_ff}]};

endmodule

// ===== sv/tpss_level_calc.sv =====
`timescale 1ns / 1ps

module tpss_level_calc (
   input  logic [tpss_pkg::LEVEL_W-1:0]  tap_level [tpss_pkg::NUM_TAPS],
   input  tpss_pkg::smooth_ctrl_type     ctrl,
   input  logic                          three_mode,
   output logic [tpss_pkg::LEVEL_W-1:0]  level
);
   import tpss_pkg::*;

   logic [LEVEL_W-1:0] nb [NUM_TAPS];
   logic [3:0]         sum;
   logic [2:0]         taps;
   logic [2:0]         step;
   logic signed [4:0]  r;
   logic signed [4:0]  top;

   always_comb begin
      for (int i = 0; i < NUM_TAPS; i++) begin
         nb[i] = three_mode ? {1'b0, tap_level[i][1]} : tap_level[i];
      end
   end

   assign step = three_mode ? 3'd1 : 3'd2;
   assign top  = three_mode ? 5'sd2 : 5'sd3;

   always_comb begin
      sum  = {2'b00, tap_level[TAP_CENTER]};
      taps = 3'd1;
      if (ctrl.h_on) begin
         sum  = sum + {2'b00, nb[TAP_LEFT]} + {2'b00, nb[TAP_RIGHT]};
         taps = taps + step;
      end
      if (ctrl.v_on) begin
         sum  = sum + {2'b00, nb[TAP_UP]} + {2'b00, nb[TAP_DOWN]};
         taps = taps + step;
      end
   end

   assign r = $signed({1'b0, sum}) - $signed({2'b00, taps});

   always_comb begin
      priority if (!ctrl.h_on && !ctrl.v_on) begin
         level = tap_level[TAP_CENTER];
      end else if (ctrl.edge_hit) begin
         level = (r > 5'sd1) ? LEVEL_W'(top) : '0;
      end else if (r > top) begin
         level = LEVEL_W'(top);
      end else if (r < 5'sd0) begin
         level = '0;
      end else begin
         level = LEVEL_W'(r);
      end
   end

endmodule

// ===== sv/tile_pixel_smoothing_sampler_top.sv =====
`timescale 1ns / 1ps

// Tile pixel sampler: holds a tile map and a glyph store and answers each
// sample item with one smoothed 2-bit grey level; map and glyph writes give no
// result. An item is taken every cycle unless the output stage stalls; the map
// read registers at the accepting edge, then the glyph read, then the output
// register that holds the level. The five taps (centre, left, right, up, down)
// are read in parallel from five copies of both memories, each with a
// registered read.
// Entries must be written before they are sampled; there is no clearing pass.
// The output stage stalls the whole pipeline while a level waits to be taken.
module tile_pixel_smoothing_sampler_top #(
   parameter int RES_X       = tpss_pkg::DEF_RES_X,
   parameter int RES_Y       = tpss_pkg::DEF_RES_Y,
   parameter int GLYPH_COUNT = tpss_pkg::DEF_GLYPH_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, map_index, map_tile, glyph_id, glyph_column, glyph_word
   input  logic [tpss_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  logic [tpss_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // level
   output logic [tpss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wen,
   input  logic                               csr_wdata
);
   import tpss_pkg::*;

   localparam int MAP_DEPTH = map_depth(RES_X, RES_Y);
   localparam int SLOT_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int GLYPH_AW  = $clog2(GLYPH_COUNT * BLK);

   req_data_type       req;
   logic               accept;
   logic               adv;

   logic               level_mode_ff;
   logic               s1_valid_ff;
   smooth_ctrl_type    s1_ctrl_ff;
   logic               s2_valid_ff;
   smooth_ctrl_type    s2_ctrl_ff;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;

   logic [SLOT_W-1:0]  slot [NUM_TAPS];
   tap_pos_type        tap_pos [NUM_TAPS];
   smooth_ctrl_type    ctrl;
   logic [LEVEL_W-1:0] tap_level [NUM_TAPS];
   logic [LEVEL_W-1:0] level;

   logic               map_we;
   logic [SLOT_W-1:0]  map_waddr;
   logic               glyph_we;
   logic [GLYPH_AW-1:0] glyph_waddr;

   assign req        = req_data_type'(req_tdata);
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign map_we      = accept && (req_tuser == CMD_MAP_WR) && (32'(req.map_index) < MAP_DEPTH);
   assign map_waddr   = SLOT_W'(req.map_index);
   assign glyph_we    = accept && (req_tuser == CMD_GLYPH_WR)
                      && (32'(req.glyph_id) < GLYPH_COUNT);
   assign glyph_waddr = GLYPH_AW'(32'(req.glyph_id) * BLK + 32'(req.glyph_column));

   tpss_tap_addr #(
      .RES_X  (RES_X),
      .RES_Y  (RES_Y),
      .SLOT_W (SLOT_W)
   ) u_addr (
      .pos_x   (req.pos_x),
      .pos_y   (req.pos_y),
      .slot    (slot),
      .tap_pos (tap_pos),
      .ctrl    (ctrl)
   );

   for (genvar g = 0; g < NUM_TAPS; g++) begin : g_lane
      tpss_tap_lane #(
         .GLYPH_COUNT (GLYPH_COUNT),
         .MAP_DEPTH   (MAP_DEPTH),
         .SLOT_W      (SLOT_W),
         .GLYPH_AW    (GLYPH_AW)
      ) u_lane (
         .clock       (clock),
         .adv         (adv),
         .map_we      (map_we),
         .map_waddr   (map_waddr),
         .map_wdata   (req.map_tile),
         .glyph_we    (glyph_we),
         .glyph_waddr (glyph_waddr),
         .glyph_wdata (req.glyph_word),
         .rd_slot     (slot[g]),
         .rd_pos      (tap_pos[g]),
         .level       (tap_level[g])
      );
   end

   tpss_level_calc u_calc (
      .tap_level  (tap_level),
      .ctrl       (s2_ctrl_ff),
      .three_mode (level_mode_ff),
      .level      (level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_mode_ff <= 1'b0;
      end else if (csr_wen) begin
         level_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept && (req_tuser == CMD_SAMPLE);
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctrl_ff   <= ctrl;
         s2_ctrl_ff   <= s1_ctrl_ff;
         rsp_level_ff <= level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - LEVEL_W)'(0), rsp_level_ff};

endmodule
